>>> rtl/uf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uf_pkg
// Shared constants, the stored element record and the controller/datapath
// command and status groups of the union-find store.
// ----------------------------------------------------------------------------
package uf_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int RANK_W       = 4;
  localparam int WEIGHT_W     = 10;
  localparam int COUNT_W      = 11;

  localparam logic [RANK_W-1:0]   RANK_INIT  = RANK_W'(1);
  localparam logic [RANK_W-1:0]   RANK_MAX   = '1;
  localparam logic [COUNT_W-1:0]  COUNT_INIT = COUNT_W'(MAX_ELEMENTS);
  localparam logic [IDX_W-1:0]    LAST_IDX   = IDX_W'(MAX_ELEMENTS - 1);

  localparam logic REQ_FIND  = 1'b0;
  localparam logic REQ_UNION = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0]    parent;
    logic [RANK_W-1:0]   rank;
    logic [WEIGHT_W-1:0] weight;
  } entry_t;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic walk_step;
    logic load_b;
    logic cap_a;
    logic cap_b;
    logic wr_lose;
    logic wr_keep;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic bad;
    logic at_root;
    logic is_union;
    logic same_root;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

>>> rtl/uf_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uf_if
// Request and response channels of the union-find store.
// ----------------------------------------------------------------------------
interface uf_req_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [uf_pkg::IDX_W-1:0]  elem_a;
  logic [uf_pkg::IDX_W-1:0]  elem_b;

  modport source (output valid, req_type, elem_a, elem_b, input ready);
  modport sink (input valid, req_type, elem_a, elem_b, output ready);
endinterface

interface uf_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [uf_pkg::IDX_W-1:0]      root_a;
  logic [uf_pkg::IDX_W-1:0]      root_b;
  logic                          merged;
  logic [uf_pkg::WEIGHT_W-1:0]   root_weight;
  logic                          bad_index;

  modport source (output valid, root_a, root_b, merged, root_weight, bad_index,
                  input ready);
  modport sink (input valid, root_a, root_b, merged, root_weight, bad_index,
                output ready);
endinterface
`default_nettype wire

>>> rtl/uf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uf_ctrl
// Sequencer: clearing sweep, root walks for a and b, link writes and
// hand-off of the result to the output register.
// ----------------------------------------------------------------------------
module uf_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire uf_pkg::status_t st,
  output uf_pkg::cmd_t        cmd
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_WALK_A = 7'b0000100,
    S_WALK_B = 7'b0001000,
    S_LINK   = 7'b0010000,
    S_GROW   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_WALK_A;
        end
      end
      S_WALK_A: begin
        if (st.bad) begin
          state_next = S_DONE;
        end else if (st.at_root) begin
          cmd.cap_a = 1'b1;
          if (st.is_union) begin
            cmd.load_b = 1'b1;
            state_next = S_WALK_B;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_WALK_B: begin
        if (st.at_root) begin
          cmd.cap_b  = 1'b1;
          state_next = S_LINK;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_LINK: begin
        if (st.same_root) begin
          state_next = S_DONE;
        end else begin
          cmd.wr_lose = 1'b1;
          state_next  = S_GROW;
        end
      end
      S_GROW: begin
        cmd.wr_keep = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/uf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uf_datapath
// Element memory, walk pointer, captured roots, link arithmetic, the
// element count register and the output register.
// ----------------------------------------------------------------------------
module uf_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire uf_pkg::cmd_t                  cmd,
  output uf_pkg::status_t                    st,
  input  wire logic                          cfg_wr_en,
  input  wire logic [uf_pkg::COUNT_W-1:0]    cfg_wr_data,
  input  wire logic                          in_req_type,
  input  wire logic [uf_pkg::IDX_W-1:0]      in_elem_a,
  input  wire logic [uf_pkg::IDX_W-1:0]      in_elem_b,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [uf_pkg::IDX_W-1:0]           out_root_a,
  output logic [uf_pkg::IDX_W-1:0]           out_root_b,
  output logic                               out_merged,
  output logic [uf_pkg::WEIGHT_W-1:0]        out_root_weight,
  output logic                               out_bad_index
);

  uf_pkg::entry_t mem [uf_pkg::MAX_ELEMENTS];
  uf_pkg::entry_t mem_q;

  logic [uf_pkg::COUNT_W-1:0]  elem_count;
  logic [uf_pkg::IDX_W-1:0]    clr_cnt;

  logic                        req_q;
  logic [uf_pkg::IDX_W-1:0]    b_q;
  logic                        bad_q;
  logic [uf_pkg::IDX_W-1:0]    walk_idx;
  logic [uf_pkg::IDX_W-1:0]    walk_idx_next;
  logic [uf_pkg::IDX_W-1:0]    ra;
  logic [uf_pkg::IDX_W-1:0]    rb;
  uf_pkg::entry_t              ra_ent;
  uf_pkg::entry_t              rb_ent;

  logic                        in_bad;
  logic                        rb_wins;
  logic [uf_pkg::IDX_W-1:0]    keep_idx;
  logic [uf_pkg::IDX_W-1:0]    lose_idx;
  uf_pkg::entry_t              keep_ent;
  uf_pkg::entry_t              lose_ent;
  logic [uf_pkg::WEIGHT_W:0]   weight_sum;
  logic [uf_pkg::WEIGHT_W-1:0] weight_new;
  logic [uf_pkg::RANK_W-1:0]   rank_new;

  logic                        wr_en;
  logic [uf_pkg::IDX_W-1:0]    wr_addr;
  uf_pkg::entry_t              wr_data;

  logic [uf_pkg::IDX_W-1:0]    res_root_a;
  logic [uf_pkg::IDX_W-1:0]    res_root_b;
  logic                        res_merged;
  logic [uf_pkg::WEIGHT_W-1:0] res_weight;

  // the count is 11 bits, so an index is out of range exactly when >= count
  assign in_bad = ({1'b0, in_elem_a} >= elem_count) ||
                  ((in_req_type == uf_pkg::REQ_UNION) && ({1'b0, in_elem_b} >= elem_count));

  always_comb begin
    if (cmd.accept) begin
      walk_idx_next = in_elem_a;
    end else if (cmd.load_b) begin
      walk_idx_next = b_q;
    end else if (cmd.walk_step) begin
      walk_idx_next = mem_q.parent;
    end else begin
      walk_idx_next = walk_idx;
    end
  end

  // link decision: lower rank goes under higher, ties keep a's root
  assign rb_wins  = rb_ent.rank > ra_ent.rank;
  assign keep_idx = rb_wins ? rb : ra;
  assign lose_idx = rb_wins ? ra : rb;
  assign keep_ent = rb_wins ? rb_ent : ra_ent;
  assign lose_ent = rb_wins ? ra_ent : rb_ent;

  assign weight_sum = {1'b0, keep_ent.weight} + {1'b0, lose_ent.weight} +
                      (uf_pkg::WEIGHT_W + 1)'(1);
  assign weight_new = weight_sum[uf_pkg::WEIGHT_W] ? '1 : weight_sum[uf_pkg::WEIGHT_W-1:0];

  always_comb begin
    rank_new = keep_ent.rank;
    if (!rb_wins && (ra_ent.rank == rb_ent.rank) && (ra_ent.rank != uf_pkg::RANK_MAX)) begin
      rank_new = ra_ent.rank + uf_pkg::RANK_W'(1);
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_cnt;
    wr_data = '{parent: clr_cnt, rank: uf_pkg::RANK_INIT, weight: '0};
    if (cmd.clear_step) begin
      wr_en = 1'b1;
    end else if (cmd.wr_lose) begin
      wr_en   = 1'b1;
      wr_addr = lose_idx;
      wr_data = '{parent: keep_idx, rank: lose_ent.rank, weight: lose_ent.weight};
    end else if (cmd.wr_keep) begin
      wr_en   = 1'b1;
      wr_addr = keep_idx;
      wr_data = '{parent: keep_idx, rank: rank_new, weight: weight_new};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[walk_idx_next];
  end

  always_comb begin
    res_root_a = '0;
    res_root_b = '0;
    res_merged = 1'b0;
    res_weight = '0;
    if (!bad_q) begin
      res_root_a = ra;
      res_weight = ra_ent.weight;
      if (req_q == uf_pkg::REQ_UNION) begin
        res_root_b = rb;
        if (ra != rb) begin
          res_merged = 1'b1;
          res_weight = weight_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_count <= uf_pkg::COUNT_INIT;
      clr_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        elem_count <= cfg_wr_data;
      end
      if (cmd.clear_step) begin
        clr_cnt <= clr_cnt + uf_pkg::IDX_W'(1);
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    walk_idx <= walk_idx_next;
    if (cmd.accept) begin
      req_q <= in_req_type;
      b_q   <= in_elem_b;
      bad_q <= in_bad;
    end
    if (cmd.cap_a) begin
      ra     <= walk_idx;
      ra_ent <= mem_q;
    end
    if (cmd.cap_b) begin
      rb     <= walk_idx;
      rb_ent <= mem_q;
    end
    if (cmd.load_out) begin
      out_root_a      <= res_root_a;
      out_root_b      <= res_root_b;
      out_merged      <= res_merged;
      out_root_weight <= res_weight;
      out_bad_index   <= bad_q;
    end
  end

  assign st.clear_last = clr_cnt == uf_pkg::LAST_IDX;
  assign st.bad        = bad_q;
  assign st.at_root    = mem_q.parent == walk_idx;
  assign st.is_union   = req_q == uf_pkg::REQ_UNION;
  assign st.same_root  = ra == rb;
  assign st.out_free   = !out_valid || out_ready;

  a_link_distinct: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_lose |-> (ra != rb))
    else $error("link write with both roots equal");

  a_keep_after_lose: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_keep |-> $past(cmd.wr_lose))
    else $error("root update without preceding link write");

  a_walk_not_root: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_step |-> (mem_q.parent != walk_idx))
    else $error("walk step taken from a root");

  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("output register overwritten while held");

endmodule
`default_nettype wire

>>> rtl/union_find_by_rank.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// union_find_by_rank
// Disjoint-set store with union by rank over 1024 elements.
// ----------------------------------------------------------------------------
// After reset the block sweeps its element memory, one entry a cycle, and
// takes no request until that sweep ends; element_count writes are taken
// throughout. Requests are handled one at a time through a memory with one
// write port and one read port whose read data is registered. A find walks
// from a to its root one parent link at a time, and a union walks from a and
// then from b; the depth of an element, its distance to the root, is at most
// about log2 of the set size under union by rank. A rejected index skips both
// walks. A new request is taken while the previous result still waits in the
// output register.
module union_find_by_rank (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [uf_pkg::COUNT_W-1:0]  cfg_wr_data,
  uf_req_if.sink                           req,
  uf_rsp_if.source                         rsp
);

  uf_pkg::cmd_t    cmd;
  uf_pkg::status_t st;

  uf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  uf_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_req_type     (req.req_type),
    .in_elem_a       (req.elem_a),
    .in_elem_b       (req.elem_b),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .out_root_a      (rsp.root_a),
    .out_root_b      (rsp.root_b),
    .out_merged      (rsp.merged),
    .out_root_weight (rsp.root_weight),
    .out_bad_index   (rsp.bad_index)
  );

endmodule
`default_nettype wire
